@@ sv/bb3_pkg.sv @@
package bb3_pkg;

    // Geometry of the row store
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W    = $clog2(MAX_WIDTH + 3);

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    // Where the result of an item comes from in the second stage
    typedef enum logic [1:0] {
        SRC_NEWER,
        SRC_FILTER,
        SRC_DIRECT
    } bb3_src_t;

    // One row store entry: horizontal results of the two previous rows
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } bb3_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } bb3_rd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        bb3_entry_t        data;
    } bb3_wr_t;

    // Clamp a written width to 1..MAX_WIDTH
    function automatic logic [WID_W-1:0] sat_width(logic [CFG_W-1:0] v);
        int unsigned t;
        t = int'(v);
        if (t < 1)
        begin
            t = 1;
        end
        if (t > MAX_WIDTH)
        begin
            t = MAX_WIDTH;
        end
        return WID_W'(t);
    endfunction

    // A height of zero acts as one row
    function automatic logic [ROW_W-1:0] sat_height(logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] h;
        h = ROW_W'(v);
        if (h == '0)
        begin
            h = ROW_W'(1);
        end
        return h;
    endfunction

endpackage

@@ sv/bb3_row_store.sv @@
module bb3_row_store (
    input  logic                clk,
    input  bb3_pkg::bb3_rd_t    rd,
    input  bb3_pkg::bb3_wr_t    wr,
    output bb3_pkg::bb3_entry_t rd_data
);
    import bb3_pkg::*;

    bb3_entry_t mem [MAX_WIDTH];
    bb3_entry_t rd_data_reg;

    // Write back and registered read, one port each
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/binomial_blur_3x3_stream.sv @@
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     func, pixel_in
// output    out        out_valid / out_ready   pixel_out, frame_end
// config    in         cfg_we (no wait)        cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; a result passes through
// the second stage, which reads the row store, and then through the output register.
// The row store needs no clearing pass: after reset the block takes items at once.
// A stalled output holds the second stage, which holds the input side; the next
// item is still taken while a result waits in the output register.
module binomial_blur_3x3_stream (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [bb3_pkg::PIX_W-1:0]     pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bb3_pkg::PIX_W-1:0]     pixel_out,
    output logic                          frame_end,
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_data
);
    import bb3_pkg::*;

    // Configuration and position
    logic [WID_W-1:0]  width_reg,  width_next;
    logic [ROW_W-1:0]  height_reg, height_next;
    logic [ADDR_W-1:0] col_reg,    col_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [PEND_W-1:0] pend_reg,   pend_next;

    // Last two raw pixels and the last column of the two previous rows
    logic [PIX_W-1:0]  win_a_reg, win_a_next;
    logic [PIX_W-1:0]  win_b_reg, win_b_next;
    logic [PIX_W-1:0]  last_older_reg, last_older_next;
    logic [PIX_W-1:0]  last_newer_reg, last_newer_next;

    // Second stage
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_emit_reg,  s1_emit_next;
    logic              s1_we_reg,    s1_we_next;
    logic              s1_last_reg,  s1_last_next;
    bb3_src_t          s1_src_reg,   s1_src_next;
    logic [ADDR_W-1:0] s1_addr_reg,  s1_addr_next;
    logic [PIX_W-1:0]  s1_h_reg,     s1_h_next;
    logic [PIX_W-1:0]  s1_direct_reg, s1_direct_next;
    logic              s1_fwd_reg,   s1_fwd_next;
    bb3_entry_t        s1_fwd_data_reg, s1_fwd_data_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  pixel_out_reg, pixel_out_next;
    logic              frame_end_reg, frame_end_next;

    // Stage zero terms
    logic              accept;
    logic              at_start;
    logic              col_is_last;
    logic [ADDR_W-1:0] x;
    logic              raw_h;
    logic [PIX_W+1:0]  hsum;
    logic [PIX_W-1:0]  h;
    logic [PEND_W-1:0] lim;
    logic [PEND_W-1:0] pend_base;
    logic [PEND_W-1:0] pend_inc;
    logic              emit_px;
    logic              drain_ok;
    logic [PEND_W-1:0] pend_dec;
    logic [ADDR_W-1:0] drain_idx;

    // Stage one terms
    logic              s1_adv;
    bb3_entry_t        rd_entry;
    logic [PIX_W+1:0]  vsum;
    logic [PIX_W-1:0]  val;

    bb3_rd_t           rd;
    bb3_wr_t           wr;
    bb3_entry_t        rd_data;

    bb3_row_store u_row_store (
        .clk     (clk),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    // Handshake between the stages
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // Position, horizontal pass and pending count
    always_comb
    begin
        at_start    = (row_reg == '0) && (col_reg == '0);
        col_is_last = (WID_W'(col_reg) == (width_reg - WID_W'(1)));
        x           = col_reg - ADDR_W'(1);
        raw_h       = (row_reg == '0) || (row_reg == (height_reg - ROW_W'(1))) || (x == '0);
        hsum        = {2'b00, win_a_reg} + {1'b0, win_b_reg, 1'b0} + {2'b00, pixel_in};
        h           = raw_h ? win_b_reg : hsum[PIX_W+1:2];

        lim         = PEND_W'(width_reg) + PEND_W'(1);
        pend_base   = at_start ? '0 : pend_reg;
        pend_inc    = pend_base + PEND_W'(1);
        emit_px     = (pend_inc > lim);

        drain_ok    = at_start && (pend_reg != '0) && (pend_reg <= lim);
        pend_dec    = pend_reg - PEND_W'(1);
        drain_idx   = ADDR_W'(PEND_W'(width_reg) - pend_reg);
    end

    // Next state of configuration, position and stage one
    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_next       = pend_reg;
        win_a_next      = win_a_reg;
        win_b_next      = win_b_reg;
        last_older_next = last_older_reg;
        last_newer_next = last_newer_reg;

        s1_valid_next   = s1_valid_reg;
        s1_emit_next    = s1_emit_reg;
        s1_we_next      = s1_we_reg;
        s1_last_next    = s1_last_reg;
        s1_src_next     = s1_src_reg;
        s1_addr_next    = s1_addr_reg;
        s1_h_next       = s1_h_reg;
        s1_direct_next  = s1_direct_reg;

        rd.en           = 1'b0;
        rd.addr         = x;

        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (!func)
            begin
                // Pixel: read the entry of the column that now completes
                rd.en          = (col_reg != '0);
                rd.addr        = x;
                s1_we_next     = (col_reg != '0);
                s1_addr_next   = x;
                s1_h_next      = h;
                s1_emit_next   = emit_px;
                s1_last_next   = 1'b0;
                s1_direct_next = last_older_reg;
                if (col_reg == '0)
                begin
                    s1_src_next = SRC_DIRECT;
                end
                else if ((row_reg == ROW_W'(1)) || (x == '0))
                begin
                    s1_src_next = SRC_NEWER;
                end
                else
                begin
                    s1_src_next = SRC_FILTER;
                end

                win_a_next = win_b_reg;
                win_b_next = pixel_in;
                pend_next  = emit_px ? pend_base : pend_inc;

                // Advance the position; the last column lives in registers
                if (col_is_last)
                begin
                    last_older_next = last_newer_reg;
                    last_newer_next = pixel_in;
                    col_next        = '0;
                    if (row_reg == (height_reg - ROW_W'(1)))
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
            else
            begin
                // Drain: release one pending result of the finished frame
                rd.en          = 1'b1;
                rd.addr        = drain_idx;
                s1_we_next     = 1'b0;
                s1_addr_next   = drain_idx;
                s1_emit_next   = drain_ok;
                s1_last_next   = (pend_dec == '0);
                if (pend_reg == lim)
                begin
                    s1_src_next    = SRC_DIRECT;
                    s1_direct_next = last_older_reg;
                end
                else if (pend_reg == PEND_W'(1))
                begin
                    s1_src_next    = SRC_DIRECT;
                    s1_direct_next = last_newer_reg;
                end
                else
                begin
                    s1_src_next    = SRC_NEWER;
                    s1_direct_next = last_newer_reg;
                end
                if (drain_ok)
                begin
                    pend_next = pend_dec;
                end
            end
        end

        // Writes to the width or height register restart the stream
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    width_next = sat_width(cfg_data);
                    col_next   = '0;
                    row_next   = '0;
                    pend_next  = '0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_next = sat_height(cfg_data);
                    col_next    = '0;
                    row_next    = '0;
                    pend_next   = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    // Vertical pass and write back; a read of the entry that stage one writes
    // back in the same cycle takes the written entry instead of the stale one
    always_comb
    begin
        rd_entry = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
        vsum = {2'b00, rd_entry.older} + {1'b0, rd_entry.newer, 1'b0} + {2'b00, s1_h_reg};
        case (s1_src_reg)
            SRC_NEWER:  val = rd_entry.newer;
            SRC_FILTER: val = vsum[PIX_W+1:2];
            SRC_DIRECT: val = s1_direct_reg;
            default:    val = rd_entry.newer;
        endcase

        wr.en         = s1_adv && s1_we_reg;
        wr.addr       = s1_addr_reg;
        wr.data.older = rd_entry.newer;
        wr.data.newer = s1_h_reg;
    end

    // Capture the write back when the item taken now reads the same entry
    always_comb
    begin
        s1_fwd_next      = s1_fwd_reg;
        s1_fwd_data_next = s1_fwd_data_reg;
        if (accept)
        begin
            s1_fwd_next      = rd.en && wr.en && (rd.addr == wr.addr);
            s1_fwd_data_next = wr.data;
        end
    end

    // Load the output register, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pixel_out_next = pixel_out_reg;
        frame_end_next = frame_end_reg;
        if (s1_adv && s1_emit_reg)
        begin
            out_valid_next = 1'b1;
            pixel_out_next = val;
            frame_end_next = s1_last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= sat_width(RESET_WIDTH);
            height_reg    <= sat_height(RESET_HEIGHT);
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            win_a_reg     <= '0;
            win_b_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            win_a_reg     <= win_a_next;
            win_b_reg     <= win_b_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        last_older_reg  <= last_older_next;
        last_newer_reg  <= last_newer_next;
        s1_emit_reg     <= s1_emit_next;
        s1_we_reg       <= s1_we_next;
        s1_last_reg     <= s1_last_next;
        s1_src_reg      <= s1_src_next;
        s1_addr_reg     <= s1_addr_next;
        s1_h_reg        <= s1_h_next;
        s1_direct_reg   <= s1_direct_next;
        s1_fwd_reg      <= s1_fwd_next;
        s1_fwd_data_reg <= s1_fwd_data_next;
        pixel_out_reg   <= pixel_out_next;
        frame_end_reg   <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

@@ sv/bb3_checker.sv @@
module bb3_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bb3_pkg::PIX_W-1:0] pixel_out,
    input logic                      frame_end
);
    import bb3_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_end))
        else $error("stalled result changed or vanished");

    // Keep taking items while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output");

    // A fresh result follows an accepted item through the second stage and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching item");

endmodule

bind binomial_blur_3x3_stream bb3_checker u_bb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
);

@@ dv/binomial_blur_3x3_stream_test.sv @@
`timescale 1ns / 1ps

module binomial_blur_3x3_stream_test;

    import bb3_pkg::*;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam int unsigned RANDOM_ITEMS  = 720;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned HOLD_AT_FIRST = 80;
    localparam int unsigned HOLD_AT_NEXT  = 450;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned REPORT_CAP    = 40;

    typedef struct {
        logic             func;
        logic [PIX_W-1:0] px;
    } pix_item_t;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } blur_out_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 func      = FUNC_PIXEL;
    logic [PIX_W-1:0]     pixel_in  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic                 frame_end;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pix_item_t   feed_q[$];
    blur_out_t   blur_due_q[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Sender and receiver pacing
    int unsigned feed_gap  = 0;
    bit          feed_calm = 1'b0;
    int unsigned take_wait = 0;
    int unsigned take_hold = 0;
    int unsigned taken     = 0;
    bit          take_calm = 1'b0;

    // Blur predictor state
    logic [CFG_W-1:0] frame_w_reg;
    logic [CFG_W-1:0] frame_h_reg;
    logic [PIX_W-1:0] hx_older [MAX_WIDTH];
    logic [PIX_W-1:0] hx_newer [MAX_WIDTH];
    logic [PIX_W-1:0] raw_win [3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      pend_count;

    binomial_blur_3x3_stream u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .frame_end (frame_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned width_eff();
        if (frame_w_reg == '0)
        begin
            return 1;
        end
        if (int'(frame_w_reg) > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return int'(frame_w_reg);
    endfunction

    function automatic int unsigned height_eff();
        return (frame_h_reg == '0) ? 1 : int'(frame_h_reg);
    endfunction

    task automatic reset_model();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            hx_older[i] = '0;
            hx_newer[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            raw_win[i] = '0;
        end
        col_pos     = 0;
        row_pos     = 0;
        pend_count  = 0;
        frame_w_reg = RESET_WIDTH;
        frame_h_reg = RESET_HEIGHT;
    endtask

    // Work out the result, if any, of one accepted item
    task automatic blur_predict(logic f, logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned hv;
        int unsigned val;
        bit          at_start;
        bit          emit;
        w        = width_eff();
        h        = height_eff();
        at_start = (row_pos == 0) && (col_pos == 0);
        hv       = 0;
        val      = 0;
        emit     = 1'b0;

        // Drain tick: release one pending result once the frame is complete
        if (f == FUNC_DRAIN)
        begin
            if (at_start && pend_count != 0 && pend_count <= w + 1)
            begin
                if (pend_count > w)
                begin
                    val = hx_older[w-1];
                end
                else
                begin
                    val = hx_newer[w-pend_count];
                end
                pend_count--;
                blur_due_q.push_back(blur_out_t'{PIX_W'(val), pend_count == 0});
            end
            return;
        end

        // Drop any undrained tail when a new frame starts
        if (at_start)
        begin
            pend_count = 0;
        end
        raw_win[0] = raw_win[1];
        raw_win[1] = raw_win[2];
        raw_win[2] = px;
        c = col_pos;

        pend_count++;
        if (pend_count > w + 1)
        begin
            emit = 1'b1;
            pend_count--;
        end

        // Horizontal pass on the pixel one column back
        if (c >= 1)
        begin
            if (row_pos == 0 || row_pos == h - 1 || c == 1)
            begin
                hv = raw_win[1];
            end
            else
            begin
                hv = (raw_win[0] + (raw_win[1] << 1) + raw_win[2]) >> 2;
            end
        end

        // Vertical pass on the position one row and one column back
        if (emit)
        begin
            if (c >= 1)
            begin
                if (row_pos == 1 || c == 1)
                begin
                    val = hx_newer[c-1];
                end
                else
                begin
                    val = (hx_older[c-1] + (hx_newer[c-1] << 1) + hv) >> 2;
                end
            end
            else
            begin
                val = hx_older[w-1];
            end
        end

        // Shift the row stores
        if (c >= 1)
        begin
            hx_older[c-1] = hx_newer[c-1];
            hx_newer[c-1] = PIX_W'(hv);
        end
        if (c == w - 1)
        begin
            hx_older[c] = hx_newer[c];
            hx_newer[c] = px;
        end

        // Advance the raster position
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end

        if (emit)
        begin
            blur_due_q.push_back(blur_out_t'{PIX_W'(val), 1'b0});
        end
    endtask

    task automatic report_mismatch(string what);
        if (mismatch_count < REPORT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Wait until nothing is queued, offered or expected, then let the pipe settle
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (feed_q.size() != 0 || in_valid || blur_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
        begin
            frame_w_reg = data;
        end
        if (idx == CFG_FRAME_HEIGHT)
        begin
            frame_h_reg = data;
        end
        if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT)
        begin
            col_pos    = 0;
            row_pos    = 0;
            pend_count = 0;
        end
    endtask

    task automatic queue_pixels(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            feed_q.push_back(pix_item_t'{FUNC_PIXEL, PIX_W'($urandom)});
        end
    endtask

    task automatic queue_drains(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            feed_q.push_back(pix_item_t'{FUNC_DRAIN, PIX_W'($urandom)});
        end
    endtask

    // Offer items from the pending queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin : feed_proc
        pix_item_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            func      <= FUNC_PIXEL;
            pixel_in  <= '0;
            feed_gap  <= 0;
            feed_calm <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (feed_gap != 0)
            begin
                in_valid <= 1'b0;
                feed_gap <= feed_gap - 1;
            end
            else if (feed_q.size() != 0)
            begin
                nxt = feed_q.pop_front();
                in_valid <= 1'b1;
                func     <= nxt.func;
                pixel_in <= nxt.px;
                if ($urandom_range(0, 23) == 0)
                begin
                    feed_calm <= !feed_calm;
                end
                feed_gap <= feed_calm ? 0 : $urandom_range(0, 14);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Take results with random stalls, and twice hold off for a long stretch
    always @(posedge clk or negedge rst_n)
    begin : take_proc
        int unsigned stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_wait <= 0;
            take_hold <= 0;
            taken     <= 0;
            take_calm <= 1'b0;
        end
        else if (take_hold != 0)
        begin
            take_hold <= take_hold - 1;
            out_ready <= (take_hold == 1);
        end
        else if (out_valid && out_ready)
        begin
            taken <= taken + 1;
            if (taken + 1 == HOLD_AT_FIRST || taken + 1 == HOLD_AT_NEXT)
            begin
                take_hold <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 23) == 0)
                begin
                    take_calm <= !take_calm;
                end
                stall = take_calm ? 0 : $urandom_range(0, 14);
                take_wait <= stall;
                out_ready <= (stall == 0);
            end
        end
        else if (take_wait != 0)
        begin
            take_wait <= take_wait - 1;
            out_ready <= (take_wait == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Check each result, then predict from each accepted item
    always @(posedge clk)
    begin : watch_proc
        blur_out_t due;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (blur_due_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result pixel_out=%0d frame_end=%0b",
                                              pixel_out, frame_end));
                end
                else
                begin
                    due = blur_due_q.pop_front();
                    if (pixel_out !== due.pixel)
                    begin
                        report_mismatch($sformatf("pixel_out=%0d, want %0d",
                                                  pixel_out, due.pixel));
                    end
                    if (frame_end !== due.last)
                    begin
                        report_mismatch($sformatf("frame_end=%0b, want %0b",
                                                  frame_end, due.last));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                blur_predict(func, pixel_in);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stim_proc
        int unsigned      w;
        int unsigned      h;
        int unsigned      area;
        int unsigned      npix;
        int unsigned      ndrain;
        int unsigned      shape;
        int unsigned      random_items;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        bit               force_cfg;

        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain with nothing pending gives nothing
        queue_drains(1);
        wait_idle();

        // 3x3 frame of alternating extremes, paused halfway
        write_reg(CFG_FRAME_WIDTH, CFG_W'(3));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(3));
        for (int i = 0; i < 5; i++)
        begin
            feed_q.push_back(pix_item_t'{FUNC_PIXEL, (i % 2) ? 8'h00 : 8'hff});
        end
        wait_idle();
        // Writes past the register list must leave the frame alone
        write_reg(CFG_SPARE_LO, CFG_W'($urandom));
        write_reg(CFG_SPARE_HI, '1);
        // Drain before the frame is complete gives nothing
        queue_drains(1);
        for (int i = 5; i < 9; i++)
        begin
            feed_q.push_back(pix_item_t'{FUNC_PIXEL, (i % 2) ? 8'h00 : 8'hff});
        end
        queue_drains(4);
        wait_idle();

        // Small frame left undrained, then overrun by the next frame
        write_reg(CFG_FRAME_WIDTH, CFG_W'(2));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(2));
        queue_pixels(8);
        queue_drains(3);
        wait_idle();

        // Widest rows: partial frame cut off by a register write
        write_reg(CFG_FRAME_WIDTH, CFG_W'(MAX_WIDTH));
        write_reg(CFG_FRAME_HEIGHT, '1);
        queue_pixels(24);
        wait_idle();

        // Width saturates, height zero acts as one row; drains in mid row give nothing
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, '0);
        queue_pixels(24);
        queue_drains(2);
        wait_idle();

        // Width zero acts as one column
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '1);
        queue_pixels(30);
        wait_idle();

        // Random frames: mostly complete and drained, some cut short or left undrained
        random_items = 0;
        force_cfg    = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            if (force_cfg || $urandom_range(0, 2) == 0)
            begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       wv = '0;
                    1:       wv = CFG_W'($urandom_range(13, 40));
                    default: wv = CFG_W'($urandom_range(1, 12));
                endcase
                case ($urandom_range(0, 9))
                    0:       hv = '0;
                    1:       hv = CFG_W'($urandom_range(7, 12));
                    default: hv = CFG_W'($urandom_range(1, 6));
                endcase
                write_reg(CFG_FRAME_WIDTH, wv);
                write_reg(CFG_FRAME_HEIGHT, hv);
            end
            force_cfg = 1'b0;
            w     = width_eff();
            h     = height_eff();
            area  = w * h;
            shape = $urandom_range(0, 9);
            npix  = (shape == 0 && area > 1) ? $urandom_range(1, area - 1) : area;
            for (int unsigned i = 0; i < npix; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    queue_drains(1);
                end
                queue_pixels(1);
                random_items++;
            end
            if (shape == 0)
            begin
                force_cfg = 1'b1;
            end
            else if (shape != 1)
            begin
                ndrain = (area < w + 1) ? area : w + 1;
                queue_drains(ndrain);
                random_items += ndrain;
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_drains(1);
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
